@@ hdl/wildcard_substitution_enumerator_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard substitution enumerator
// Clocked concurrent checks that are switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_SUBSTITUTION_ENUMERATOR_MACROS_SVH
`define WILDCARD_SUBSTITUTION_ENUMERATOR_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define WSE_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// Check that a condition never occurs outside reset
`define WSE_ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error(msg);

`endif

@@ hdl/wse_pkg.sv @@
// ---------------------------------------------------------------------------
// Wildcard substitution enumerator package
// Shared widths, codes and state type of the enumerator.
// ---------------------------------------------------------------------------
package wse_pkg;

  // Default longest keyword in bytes
  localparam int MAX_LEN_DEF = 8;

  // Fixed field widths
  localparam int KW_BYTES    = 8;
  localparam int KW_W        = 8 * KW_BYTES;
  localparam int LEN_W       = 4;
  localparam int MASK_W      = 8;
  localparam int ORD_W       = 7;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 80;

  // Byte written at a wildcard position
  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  // Request kind carried on the input tuser
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_NEXT  = 1'b1
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_EMIT,
    ST_REFILL
  } wse_state_t;

endpackage

@@ hdl/wse_subst.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte substitution
// Replaces every keyword byte whose mask bit is set by the wildcard byte.
// ---------------------------------------------------------------------------
module wse_subst
  import wse_pkg::*;
(
  input  logic [KW_W-1:0]   keyword,
  input  logic [MASK_W-1:0] mask,
  output logic [KW_W-1:0]   variant
);

  // Select per byte between keyword and wildcard
  always_comb begin
    for (int i = 0; i < KW_BYTES; i++) begin
      variant[8*i +: 8] = mask[i] ? WILDCARD_BYTE : keyword[8*i +: 8];
    end
  end

endmodule

@@ hdl/wildcard_substitution_enumerator.sv @@
// The block takes no new word until a start, scan, refill or held output is through;
// s_tready is high only while idle. After a variant, r = 0 to k positions are
// rewritten before the next word is taken; k is the wildcard count.
// The position memory sets the pace: k writes on start, k reads per scan, r writes back.
// Reset: synchronous, active high; leaves the block exhausted and idle.
// ---------------------------------------------------------------------------
// Wildcard substitution enumerator
// Walks all k-subsets of keyword positions in lexicographic order and emits
// the keyword with the chosen bytes replaced by '*'. Positions live in a
// small memory that is scanned backward and rewritten from the pivot on.
// ---------------------------------------------------------------------------
`include "wildcard_substitution_enumerator_macros.svh"

module wildcard_substitution_enumerator
  import wse_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [63:0] keyword, [67:64] keyword_length, [71:68] wildcard_count
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [63:0] variant, [71:64] position_mask, [78:72] variant_index, [79] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] exhausted
  output logic                  m_tuser
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  // Input word fields
  logic [KW_W-1:0]  in_keyword;
  logic [LEN_W-1:0] in_length;
  logic [LEN_W-1:0] in_count;
  kind_t            in_kind;

  assign in_keyword = s_tdata[KW_W-1:0];
  assign in_length  = s_tdata[KW_W +: LEN_W];
  assign in_count   = s_tdata[KW_W+LEN_W +: LEN_W];
  assign in_kind    = kind_t'(s_tuser);

  // Control and stored keyword
  wse_state_t        state, state_next;
  logic [KW_W-1:0]   kw, kw_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  cnt, cnt_next;
  logic              done, done_next;
  logic [ORD_W-1:0]  emitted, emitted_next;

  // Scan and refill bookkeeping
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              scan_issue, scan_issue_next;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [MASK_W-1:0] mask_acc, mask_acc_next;
  logic              pivot_found, pivot_found_next;
  logic [IDX_W-1:0]  pivot_idx, pivot_idx_next;
  logic [IDX_W-1:0]  fill_val, fill_val_next;
  logic [IDX_W-1:0]  wr_idx, wr_idx_next;

  // Output register
  logic              out_valid;
  logic [KW_W-1:0]   out_variant;
  logic [MASK_W-1:0] out_mask;
  logic [ORD_W-1:0]  out_index;
  logic              out_exh;
  logic              out_load;
  logic              out_free;

  // Position memory
  logic [IDX_W-1:0]  pos_mem [MAX_LEN];
  logic [IDX_W-1:0]  mem_rdata;
  logic [IDX_W-1:0]  mem_wdata;
  logic              mem_we;
  logic              rd_en;

  // Helpers
  logic [LEN_W-1:0]  in_len_sat;
  logic [KW_W-1:0]   in_kw_masked;
  logic [LEN_W-1:0]  cnt_last;
  logic [LEN_W-1:0]  limit;
  logic              is_pivot;
  logic [KW_W-1:0]   subst_variant;

  // Saturate the length and clear bytes beyond it
  always_comb begin
    in_len_sat = (in_length > MAX_LEN_L) ? MAX_LEN_L : in_length;
    for (int i = 0; i < KW_BYTES; i++) begin
      in_kw_masked[8*i +: 8] = (LEN_W'(i) < in_len_sat) ? in_keyword[8*i +: 8] : 8'h00;
    end
  end

  // Highest value a position may hold before it must backtrack
  assign cnt_last = cnt - LEN_W'(1);
  assign limit    = len - cnt + LEN_W'(rd_idx);
  assign is_pivot = rd_valid && !pivot_found && (LEN_W'(mem_rdata) < limit);
  assign out_free = !out_valid || m_tready;

  // Substitute wildcards into the stored keyword
  wse_subst u_subst (
    .keyword (kw),
    .mask    (mask_acc),
    .variant (subst_variant)
  );

  // Next state and datapath control
  always_comb begin
    state_next       = state;
    kw_next          = kw;
    len_next         = len;
    cnt_next         = cnt;
    done_next        = done;
    emitted_next     = emitted;
    scan_idx_next    = scan_idx;
    scan_issue_next  = scan_issue;
    mask_acc_next    = mask_acc;
    pivot_found_next = pivot_found;
    pivot_idx_next   = pivot_idx;
    fill_val_next    = fill_val;
    wr_idx_next      = wr_idx;
    s_tready         = 1'b0;
    mem_we           = 1'b0;
    mem_wdata        = wr_idx;
    rd_en            = 1'b0;
    out_load         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_kind == KIND_START) begin
            kw_next      = in_kw_masked;
            len_next     = in_len_sat;
            cnt_next     = in_count;
            emitted_next = '0;
            wr_idx_next  = '0;
            if (in_count == '0 || in_count > in_len_sat) begin
              done_next  = 1'b1;
              state_next = ST_EMIT;
            end else begin
              done_next  = 1'b0;
              state_next = ST_INIT;
            end
          end else if (done) begin
            state_next = ST_EMIT;
          end else begin
            scan_idx_next    = IDX_W'(cnt_last);
            scan_issue_next  = 1'b1;
            mask_acc_next    = '0;
            pivot_found_next = 1'b0;
            state_next       = ST_SCAN;
          end
        end
      end

      // Write the first subset 0..k-1
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = wr_idx;
        if (LEN_W'(wr_idx) == cnt_last) begin
          scan_idx_next    = IDX_W'(cnt_last);
          scan_issue_next  = 1'b1;
          mask_acc_next    = '0;
          pivot_found_next = 1'b0;
          state_next       = ST_SCAN;
        end else begin
          wr_idx_next = wr_idx + IDX_W'(1);
        end
      end

      // Read positions from last to first, build mask, find pivot
      ST_SCAN: begin
        rd_en = scan_issue;
        if (scan_issue) begin
          if (scan_idx == '0) begin
            scan_issue_next = 1'b0;
          end else begin
            scan_idx_next = scan_idx - IDX_W'(1);
          end
        end
        if (rd_valid) begin
          mask_acc_next = mask_acc | (MASK_W'(1) << mem_rdata);
          if (is_pivot) begin
            pivot_found_next = 1'b1;
            pivot_idx_next   = rd_idx;
            fill_val_next    = mem_rdata + IDX_W'(1);
          end
          if (rd_idx == '0) begin
            state_next = ST_EMIT;
          end
        end
      end

      // Hand the result to the output register
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (done) begin
            state_next = ST_IDLE;
          end else begin
            emitted_next = emitted + ORD_W'(1);
            if (pivot_found) begin
              wr_idx_next = pivot_idx;
              state_next  = ST_REFILL;
            end else begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end
          end
        end
      end

      // Advance the pivot and pack later positions right behind it
      ST_REFILL: begin
        mem_we        = 1'b1;
        mem_wdata     = fill_val;
        fill_val_next = fill_val + IDX_W'(1);
        if (LEN_W'(wr_idx) == cnt_last) begin
          state_next = ST_IDLE;
        end else begin
          wr_idx_next = wr_idx + IDX_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      len        <= '0;
      cnt        <= '0;
      done       <= 1'b1;
      emitted    <= '0;
      scan_issue <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      len        <= len_next;
      cnt        <= cnt_next;
      done       <= done_next;
      emitted    <= emitted_next;
      scan_issue <= scan_issue_next;
      rd_valid   <= rd_en;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kw          <= kw_next;
    scan_idx    <= scan_idx_next;
    rd_idx      <= scan_idx;
    mask_acc    <= mask_acc_next;
    pivot_found <= pivot_found_next;
    pivot_idx   <= pivot_idx_next;
    fill_val    <= fill_val_next;
    wr_idx      <= wr_idx_next;
    if (out_load) begin
      out_variant <= done ? '0 : subst_variant;
      out_mask    <= done ? '0 : mask_acc;
      out_index   <= done ? '0 : emitted;
      out_exh     <= done;
    end
  end

  // Position memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[wr_idx] <= mem_wdata;
    end
    if (rd_en) begin
      mem_rdata <= pos_mem[scan_idx];
    end
  end

  // Output word
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_index, out_mask, out_variant};
  assign m_tuser  = out_exh;

  // Checks
  `WSE_ASSERT(a_exh_zero, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == '0),
              "exhausted word carries data")
  `WSE_ASSERT(a_mask_count, clk, rst,
              (out_load && !done) |-> ($countones(mask_acc) == cnt),
              "mask popcount differs from wildcard count")
  `WSE_ASSERT_NEVER(a_port_clash, clk, rst, mem_we && rd_en,
                    "position memory read and written together")
  `WSE_ASSERT(a_refill_range, clk, rst,
              (mem_we && (state == ST_REFILL)) |-> (LEN_W'(fill_val) < len),
              "refilled position beyond keyword")

endmodule

@@ tb/wildcard_substitution_enumerator_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Wildcard substitution enumerator testbench
// Feeds start and next words to the enumerator. A built-in model predicts
// every variant, mask, ordinal and exhausted flag, and the output words are
// checked against those predictions in order. Both sides stall at random.
// ---------------------------------------------------------------------------
module wildcard_substitution_enumerator_tb;
  import wse_pkg::*;

  localparam int KEY_MAX    = MAX_LEN_DEF;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_WAIT = 40;
  localparam int CALM_TAIL  = 80;

  // One input word as queued for the driver
  typedef struct {
    kind_t       kind;
    logic [63:0] keyword;
    logic [3:0]  klen;
    logic [3:0]  kcnt;
  } request_t;

  // One predicted output word
  typedef struct {
    logic [63:0] variant;
    logic [7:0]  mask;
    logic [6:0]  ordinal;
    logic        exhausted;
  } variant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = KIND_START;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  request_t requests[$];
  variant_t variants_due[$];
  request_t in_flight;
  int       mismatches = 0;
  int       cycles = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       src_bursty = 1'b1;
  bit       sink_bursty = 1'b1;
  logic     calm_tail = 1'b0;

  // Model state of the enumerator
  logic [63:0] kw_q = '0;
  int          len_q = 0;
  int          cnt_q = 0;
  int          pos_q[KEY_MAX];
  logic [6:0]  ordinal_q = '0;
  bit          spent_q = 1'b1;

  wildcard_substitution_enumerator #(.MAX_LEN(KEY_MAX)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Compute the answer to one accepted word and step the model
  function automatic variant_t next_variant(request_t req);
    variant_t r;
    int       l;
    int       i;
    int       j;
    int       pivot;
    bit       moved;
    r = '{default: '0};
    if (req.kind == KIND_START) begin
      l = (req.klen > KEY_MAX) ? KEY_MAX : int'(req.klen);
      kw_q = (l >= 8) ? req.keyword : req.keyword & ((64'd1 << (8 * l)) - 64'd1);
      len_q = l;
      cnt_q = int'(req.kcnt);
      ordinal_q = '0;
      for (i = 0; i < KEY_MAX; i++)
        pos_q[i] = (i < cnt_q) ? i : 0;
      spent_q = (cnt_q == 0) || (cnt_q > len_q);
    end
    if (spent_q) begin
      r.exhausted = 1'b1;
      return r;
    end
    r.variant = kw_q;
    for (i = 0; i < cnt_q && i < KEY_MAX; i++) begin
      r.variant[8 * (pos_q[i] & 7) +: 8] = WILDCARD_BYTE;
      r.mask[pos_q[i] & 7] = 1'b1;
    end
    r.ordinal = ordinal_q;
    ordinal_q = ordinal_q + 7'd1;
    // Backtrack from the last position to the first one that can still move
    moved = 1'b0;
    for (pivot = cnt_q - 1; pivot >= 0 && !moved; pivot--) begin
      if (pos_q[pivot] < len_q - cnt_q + pivot) begin
        pos_q[pivot]++;
        for (j = pivot + 1; j < cnt_q; j++)
          pos_q[j] = pos_q[j - 1] + 1;
        moved = 1'b1;
      end
    end
    if (!moved)
      spent_q = 1'b1;
    return r;
  endfunction

  task automatic queue_word(kind_t kind, logic [63:0] keyword, logic [3:0] klen,
                            logic [3:0] kcnt);
    request_t req;
    req.kind = kind;
    req.keyword = keyword;
    req.klen = klen;
    req.kcnt = kcnt;
    requests.push_back(req);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Driver: hold a word until taken, then move on or idle for a burst
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        variants_due.push_back(next_variant(in_flight));
      if ($urandom_range(0, 63) == 0)
        src_bursty = !src_bursty;
      calm_tail <= (requests.size() < CALM_TAIL);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (requests.size() > 0) begin
          in_flight = requests.pop_front();
          s_tdata <= {in_flight.kcnt, in_flight.klen, in_flight.keyword};
          s_tuser <= in_flight.kind;
          s_tvalid <= 1'b1;
          if (!calm_tail && src_bursty && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken word against the oldest prediction
  always @(posedge clk) begin
    variant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (variants_due.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[63:0], '0);
        end else begin
          want = variants_due.pop_front();
          if (m_tdata[63:0] !== want.variant)
            report_mismatch("variant", m_tdata[63:0], want.variant);
          if (m_tdata[71:64] !== want.mask)
            report_mismatch("position_mask", 64'(m_tdata[71:64]), 64'(want.mask));
          if (m_tdata[78:72] !== want.ordinal)
            report_mismatch("variant_index", 64'(m_tdata[78:72]), 64'(want.ordinal));
          if (m_tdata[79] !== 1'b0)
            report_mismatch("pad bit", 64'(m_tdata[79]), 64'd0);
          if (m_tuser !== want.exhausted)
            report_mismatch("exhausted", 64'(m_tuser), 64'(want.exhausted));
        end
      end
      if ($urandom_range(0, 63) == 0)
        sink_bursty = !sink_bursty;
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm_tail && sink_bursty && $urandom_range(0, 7) == 0)
          recv_gap = $urandom_range(1, 7);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int          i;
    int          roll;
    int          klen;
    int          kcnt;
    int          combos;
    int          nexts;
    logic [63:0] kw;

    // Directed: next before any start, empty and oversized counts
    queue_word(KIND_NEXT, '1, 4'd8, 4'd1);
    queue_word(KIND_START, '1, 4'd8, 4'd0);
    queue_word(KIND_NEXT, '0, 4'd0, 4'd0);
    queue_word(KIND_START, 64'h0123_4567_89AB_CDEF, 4'd3, 4'd5);
    queue_word(KIND_START, '1, 4'd0, 4'd0);
    // Saturated length with every byte a wildcard, then repeat exhaustion
    queue_word(KIND_START, '1, 4'd12, 4'd8);
    queue_word(KIND_NEXT, '1, 4'd15, 4'd15);
    queue_word(KIND_NEXT, '0, 4'd15, 4'd15);
    // Single wildcard walking a full-length zero keyword
    queue_word(KIND_START, '0, 4'd15, 4'd1);
    repeat (8) queue_word(KIND_NEXT, '0, 4'd0, 4'd0);
    // Bytes beyond the length must come back zero
    queue_word(KIND_START, '1, 4'd3, 4'd2);
    repeat (3) queue_word(KIND_NEXT, '1, 4'd8, 4'd8);
    // Count above the largest length
    queue_word(KIND_START, 64'hFEDC_BA98_7654_3210, 4'd8, 4'd9);
    queue_word(KIND_START, 64'h0000_0000_0000_0041, 4'd1, 4'd1);
    queue_word(KIND_NEXT, '0, 4'd0, 4'd0);
    queue_word(KIND_NEXT, '0, 4'd0, 4'd0);

    // Random: mostly complete walks, some cut short, some noise
    while (requests.size() < 820) begin
      roll = $urandom_range(0, 9);
      kw = {$urandom, $urandom};
      if (roll == 0) begin
        queue_word(KIND_START, kw, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 3))
          queue_word(KIND_NEXT, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
      end else if (roll == 1) begin
        queue_word(KIND_NEXT, kw, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else begin
        klen = $urandom_range(1, KEY_MAX);
        kcnt = $urandom_range(1, klen);
        combos = 1;
        for (i = 0; i < kcnt; i++)
          combos = combos * (klen - i) / (i + 1);
        if ($urandom_range(0, 3) == 0)
          nexts = $urandom_range(0, combos - 1);
        else
          nexts = combos - 1 + $urandom_range(0, 2);
        queue_word(KIND_START, kw, 4'(klen), 4'(kcnt));
        repeat (nexts)
          queue_word(KIND_NEXT, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words sent, all answers seen, then let the block settle
    while (requests.size() > 0 || s_tvalid) @(posedge clk);
    while (variants_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
